// ===== rtl/source_location_delta_decoder_top_macros.svh =====
// Assertion helpers for the location delta decoder.
`ifndef SOURCE_LOCATION_DELTA_DECODER_TOP_MACROS_SVH
`define SOURCE_LOCATION_DELTA_DECODER_TOP_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define SLDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define SLDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sldd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sldd_pkg;

  localparam int unsigned LOC_W   = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned REC_W   = 40;  // bytes 1..5 of an absolute entry

  localparam logic [LOC_W-1:0] MAX_BYTES = 16'hffff;
  localparam logic [LOC_W-1:0] BIAS      = 16'd63;

  localparam logic [1:0] HDR_ABS = 2'b11;
  localparam logic [1:0] HDR_REL = 2'b10;

  localparam logic [PHASE_W-1:0] PHASE_HEADER   = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_ABS_LAST = 3'd6;
  localparam logic [PHASE_W-1:0] PHASE_REL      = 3'd7;

  typedef enum logic [IDX_W-1:0] {
    REG_TARGET_COUNT = 2'd0,
    REG_START_COL    = 2'd1,
    REG_START_LINE   = 2'd2,
    REG_START_FILE   = 2'd3
  } reg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_COUNT = 2'd0,
    STATUS_END   = 2'd1,
    STATUS_TRUNC = 2'd2
  } status_t;

  function automatic logic [LOC_W-1:0] add_biased(input logic [LOC_W-1:0] v,
                                                  input logic [6:0] d);
    add_biased = v + {{(LOC_W-7){1'b0}}, d} - BIAS;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sldd_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sldd_byte_if;
  logic                            valid;
  logic                            ready;
  logic                            first_byte;
  logic [sldd_pkg::BYTE_W-1:0]     data_byte;
  logic                            last_byte;

  modport source (output valid, first_byte, data_byte, last_byte, input ready);
  modport sink (input valid, first_byte, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/sldd_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sldd_result_if;
  logic                          valid;
  logic                          ready;
  logic [sldd_pkg::LOC_W-1:0]    col;
  logic [sldd_pkg::LOC_W-1:0]    line;
  logic [sldd_pkg::LOC_W-1:0]    file_id;
  logic [sldd_pkg::STAT_W-1:0]   status;
  logic [sldd_pkg::LOC_W-1:0]    bytes_used;

  modport source (output valid, col, line, file_id, status, bytes_used, input ready);
  modport sink (input valid, col, line, file_id, status, bytes_used, output ready);
endinterface

`default_nettype wire

// ===== rtl/sldd_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sldd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sldd_pkg::IDX_W-1:0]   index;
  logic [sldd_pkg::LOC_W-1:0]   value;

  modport source (output valid, index, value, input ready);
  modport sink (input valid, index, value, output ready);
endinterface

`default_nettype wire

// ===== rtl/source_location_delta_decoder_top.sv =====
// Output: the result (if any) of an accepted word is registered and shows in the cycle after it is accepted.
// Throughput: one byte word per cycle; the single result register is the only limit,
//   so input stalls only while a result waits and the sink is not ready.
// Reset (rst, synchronous, active high): decoder idle until a word with first_byte,
//   registers and location cleared to zero, no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "source_location_delta_decoder_top_macros.svh"

module source_location_delta_decoder_top (
  input  wire logic    clk,
  input  wire logic    rst,
  sldd_byte_if.sink    data_in,
  sldd_result_if.source result,
  sldd_cfg_if.sink     cfg
);

  // configuration
  logic [sldd_pkg::LOC_W-1:0]       target_count, start_col, start_line, start_file;

  // decode state
  logic [sldd_pkg::LOC_W-1:0]       cur_col, cur_line, cur_file;
  logic [sldd_pkg::REC_W-1:0]       rec_bytes;
  logic [sldd_pkg::PHASE_W-1:0]     phase;
  logic [5:0]                       rel_high;
  logic [sldd_pkg::LOC_W-1:0]       entry_count, byte_count;
  logic                             finished;

  // result register
  logic                             out_valid;
  logic [sldd_pkg::LOC_W-1:0]       out_col, out_line, out_file, out_bytes;
  logic [sldd_pkg::STAT_W-1:0]      out_status;

  // next values
  logic [sldd_pkg::LOC_W-1:0]       cur_col_next, cur_line_next, cur_file_next;
  logic [sldd_pkg::REC_W-1:0]       rec_bytes_next;
  logic [sldd_pkg::PHASE_W-1:0]     phase_next;
  logic [5:0]                       rel_high_next;
  logic [sldd_pkg::LOC_W-1:0]       entry_count_next, byte_count_next;
  logic                             finished_next;
  logic [sldd_pkg::LOC_W-1:0]       res_col, res_line, res_file;
  sldd_pkg::status_t                res_status;

  logic                             accept, emit, done;
  logic [sldd_pkg::LOC_W-1:0]       entry_inc;
  logic [6:0]                       line_delta;
  logic [sldd_pkg::BYTE_W-1:0]      b;

  assign data_in.ready = !out_valid || result.ready;
  assign accept        = data_in.valid && data_in.ready;
  assign cfg.ready     = 1'b1;
  assign b             = data_in.data_byte;
  assign line_delta    = {rel_high, b[7]};

  always_comb begin
    cur_col_next     = cur_col;
    cur_line_next    = cur_line;
    cur_file_next    = cur_file;
    rec_bytes_next   = rec_bytes;
    phase_next       = phase;
    rel_high_next    = rel_high;
    entry_count_next = entry_count;
    byte_count_next  = byte_count;
    finished_next    = finished;
    res_col          = cur_col;
    res_line         = cur_line;
    res_file         = cur_file;
    res_status       = sldd_pkg::STATUS_COUNT;
    emit             = 1'b0;
    done             = 1'b0;
    entry_inc        = '0;

    if (accept && data_in.first_byte) begin
      // restart from the configured location
      cur_col_next     = start_col;
      cur_line_next    = start_line;
      cur_file_next    = start_file;
      phase_next       = sldd_pkg::PHASE_HEADER;
      rel_high_next    = '0;
      entry_count_next = '0;
      byte_count_next  = '0;
      finished_next    = 1'b0;
    end

    if (accept && data_in.first_byte && target_count == '0) begin
      res_col       = start_col;
      res_line      = start_line;
      res_file      = start_file;
      emit          = 1'b1;
      finished_next = 1'b1;
    end else if (accept && !finished_next) begin
      if (byte_count_next != sldd_pkg::MAX_BYTES) begin
        byte_count_next = byte_count_next + 1'b1;
      end

      case (phase_next)
        sldd_pkg::PHASE_HEADER: begin
          if (b[7:6] == sldd_pkg::HDR_ABS) begin
            phase_next = 3'd1;
          end else if (b[7:6] == sldd_pkg::HDR_REL) begin
            rel_high_next = b[5:0];
            phase_next    = sldd_pkg::PHASE_REL;
          end else begin
            cur_col_next = sldd_pkg::add_biased(cur_col_next, b[6:0]);
            done         = 1'b1;
          end
        end
        sldd_pkg::PHASE_REL: begin
          cur_col_next  = sldd_pkg::add_biased(cur_col_next, b[6:0]);
          cur_line_next = sldd_pkg::add_biased(cur_line_next, line_delta);
          phase_next    = sldd_pkg::PHASE_HEADER;
          done          = 1'b1;
        end
        sldd_pkg::PHASE_ABS_LAST: begin
          cur_col_next  = rec_bytes[15:0];
          cur_line_next = rec_bytes[31:16];
          cur_file_next = {b, rec_bytes[39:32]};
          phase_next    = sldd_pkg::PHASE_HEADER;
          done          = 1'b1;
        end
        default: begin
          // absolute payload bytes one to five: capture into the record
          case (phase_next)
            3'd1:    rec_bytes_next[7:0]   = b;
            3'd2:    rec_bytes_next[15:8]  = b;
            3'd3:    rec_bytes_next[23:16] = b;
            3'd4:    rec_bytes_next[31:24] = b;
            default: rec_bytes_next[39:32] = b;
          endcase
          phase_next = phase_next + 1'b1;
        end
      endcase

      res_col  = cur_col_next;
      res_line = cur_line_next;
      res_file = cur_file_next;

      if (done) begin
        entry_inc        = entry_count_next + 1'b1;
        entry_count_next = entry_inc;
        if (entry_inc == target_count) begin
          emit = 1'b1;
        end else if (data_in.last_byte) begin
          emit       = 1'b1;
          res_status = sldd_pkg::STATUS_END;
        end
      end else if (data_in.last_byte) begin
        emit       = 1'b1;
        res_status = sldd_pkg::STATUS_TRUNC;
        res_col    = start_col;
        res_line   = start_line;
        res_file   = start_file;
      end

      if (emit) begin
        finished_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_count <= '0;
      start_col    <= '0;
      start_line   <= '0;
      start_file   <= '0;
      cur_col      <= '0;
      cur_line     <= '0;
      cur_file     <= '0;
      phase        <= sldd_pkg::PHASE_HEADER;
      rel_high     <= '0;
      entry_count  <= '0;
      byte_count   <= '0;
      finished     <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (sldd_pkg::reg_idx_t'(cfg.index))
          sldd_pkg::REG_TARGET_COUNT: target_count <= cfg.value;
          sldd_pkg::REG_START_COL:    start_col    <= cfg.value;
          sldd_pkg::REG_START_LINE:   start_line   <= cfg.value;
          sldd_pkg::REG_START_FILE:   start_file   <= cfg.value;
          default: ;
        endcase
      end
      cur_col     <= cur_col_next;
      cur_line    <= cur_line_next;
      cur_file    <= cur_file_next;
      phase       <= phase_next;
      rel_high    <= rel_high_next;
      entry_count <= entry_count_next;
      byte_count  <= byte_count_next;
      finished    <= finished_next;
      // drop the result once taken; load a new one on emit
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_bytes <= rec_bytes_next;
    if (emit) begin
      out_col    <= res_col;
      out_line   <= res_line;
      out_file   <= res_file;
      out_status <= res_status;
      out_bytes  <= byte_count_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.col        = out_col;
  assign result.line       = out_line;
  assign result.file_id    = out_file;
  assign result.status     = out_status;
  assign result.bytes_used = out_bytes;

  `SLDD_ASSERT_NEXT(a_emit_loads, emit, out_valid && finished, "emit did not load result")
  `SLDD_ASSERT_NEXT(a_idle_holds, accept && finished && !data_in.first_byte, $stable(byte_count) && $stable(cur_col) && $stable(entry_count), "idle word changed state")
  `SLDD_ASSERT_NEXT(a_zero_target, accept && data_in.first_byte && target_count == '0, out_bytes == '0 && out_col == $past(start_col), "zero target result wrong")

endmodule

`default_nettype wire
